### sv/rdc_pkg.sv
package rdc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int BASE_W     = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 7;

	// front queue
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// digit stack and divider step count
	localparam int SP_W    = $clog2(VALUE_BITS + 1);
	localparam int IDX_W   = $clog2(VALUE_BITS);
	localparam int STEP_W  = $clog2(VALUE_BITS);

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [BASE_W-1:0]     base;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
		logic              bad_base;
	} out_item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [BASE_W-1:0]     base;
		logic                  bad;
	} job_t;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [BASE_W-1:0]     divisor;
	} div_cmd_t;

	typedef struct packed {
		logic                  done;
		logic [VALUE_BITS-1:0] quotient;
		logic [DIGIT_W-1:0]    remainder;
	} div_res_t;

	// '0'-'9' then 'A'-'F'
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = CHAR_W'(d);
		if (d < DIGIT_W'(10)) begin
			digit_ascii = CHAR_W'(7'h30) + d_ext;
		end else begin
			digit_ascii = CHAR_W'(7'h37) + d_ext;
		end
	endfunction

endpackage

### sv/rdc_front.sv
module rdc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rdc_pkg::in_item_t item,
	output logic             job_valid,
	output rdc_pkg::job_t    job,
	input  logic             job_pop
);
	import rdc_pkg::*;

	job_t               ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               wr_en;
	logic               rd_en;
	job_t               new_job;

	assign full      = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign job_valid = (cnt_q != '0);
	assign job       = ent_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = job_pop && job_valid;

	// classify at the door
	always_comb begin
		new_job.value = item.value;
		new_job.base  = item.base;
		new_job.bad   = (item.base < BASE_MIN) || (item.base > BASE_MAX);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(wr_en) - Q_CNT_W'(rd_en);
		end
	end

endmodule

### sv/rdc_div.sv
module rdc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rdc_pkg::div_cmd_t cmd,
	output rdc_pkg::div_res_t res
);
	import rdc_pkg::*;

	logic [VALUE_BITS-1:0] dvd_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BASE_W-1:0]     dsr_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIGIT_W:0]      trial;
	logic                  ge;
	logic [DIGIT_W:0]      diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dvd_q[VALUE_BITS-1]};
	assign ge    = (trial >= (DIGIT_W+1)'(dsr_q));
	assign diff  = trial - (DIGIT_W+1)'(dsr_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			rem_q <= '0;
			dsr_q <= cmd.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = dvd_q;
	assign res.remainder = rem_q;

endmodule

### sv/rdc_back.sv
module rdc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  rdc_pkg::job_t      job,
	output logic               job_pop,
	output rdc_pkg::div_cmd_t  div_cmd,
	input  rdc_pkg::div_res_t  div_res,
	output logic               empty,
	input  logic               pop,
	output rdc_pkg::out_item_t result
);
	import rdc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_ERR   = 2'd3;

	logic [1:0]         state_q;
	logic [DIGIT_W-1:0] stk_q [VALUE_BITS];
	logic [SP_W-1:0]    sp_q;
	logic [SP_W-1:0]    sp_m1;
	logic [BASE_W-1:0]  base_q;
	out_item_t          out_q;
	logic               out_valid_q;
	logic               slot_free;
	logic               stk_push;
	logic               load_digit;
	logic               load_err;

	assign slot_free = !out_valid_q || pop;
	assign sp_m1     = sp_q - SP_W'(1);
	assign empty     = !out_valid_q;
	assign result    = out_q;

	assign job_pop    = (state_q == ST_IDLE) && job_valid;
	assign stk_push   = (state_q == ST_DIV) && div_res.done;
	assign load_digit = (state_q == ST_DRAIN) && slot_free;
	assign load_err   = (state_q == ST_ERR) && slot_free;

	always_comb begin
		div_cmd.start    = 1'b0;
		div_cmd.dividend = job.value;
		div_cmd.divisor  = job.base;
		if (job_pop && !job.bad) begin
			div_cmd.start = 1'b1;
		end else if (stk_push && (div_res.quotient != '0)) begin
			div_cmd.start    = 1'b1;
			div_cmd.dividend = div_res.quotient;
			div_cmd.divisor  = base_q;
		end
	end

	// radix of the job in progress, reused on every restart
	always_ff @(posedge clk) begin
		if (job_pop) begin
			base_q <= job.base;
		end
		if (stk_push) begin
			stk_q[sp_q[IDX_W-1:0]] <= div_res.remainder;
		end
		if (load_digit) begin
			out_q.digit_char <= digit_ascii(stk_q[sp_m1[IDX_W-1:0]]);
			out_q.last       <= (sp_q == SP_W'(1));
			out_q.bad_base   <= 1'b0;
		end else if (load_err) begin
			out_q.digit_char <= '0;
			out_q.last       <= 1'b1;
			out_q.bad_base   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_digit || load_err) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (stk_push) begin
				sp_q <= sp_q + SP_W'(1);
			end else if (load_digit) begin
				sp_q <= sp_m1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						state_q <= job.bad ? ST_ERR : ST_DIV;
					end
				end
				ST_DIV: begin
					if (stk_push && (div_res.quotient == '0)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load_digit && (sp_q == SP_W'(1))) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (load_err) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/radix_digit_converter_unit.sv
// sequence: one division per digit into the digit stack, then the digits drain most
//   significant first through the result register, held up by pop stalls
// throughput: one item at a time in the back end; the shared bit-serial divider sets
//   the rate. a bad base gives its lone result without a division
// reset: arst_n clears the front queue, the sequencer, the digit stack pointer and the
//   result register; all queues come up empty
module radix_digit_converter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rdc_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output rdc_pkg::out_item_t result
);
	import rdc_pkg::*;

	// front to back: classified jobs
	logic     job_valid;
	logic     job_pop;
	job_t     job;

	// back to divider
	div_cmd_t div_cmd;
	div_res_t div_res;

	// front: takes beats, flags a bad base, holds up to two jobs
	rdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	// shared divider: one quotient bit per cycle, remainder below 16
	rdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	// back: repeated division into the digit stack, then drain most significant first
	// into a one-beat result register
	rdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.div_cmd   (div_cmd),
		.div_res   (div_res),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// an error beat is always a lone zero character
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.bad_base) |-> (result.last && (result.digit_char == '0)))
		else $error("bad base beat malformed");

	// a good beat always carries a printable digit
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.bad_base) |-> (result.digit_char >= CHAR_W'(7'h30)))
		else $error("digit character out of range");

	// the back end only takes a job that is there
	assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job taken from empty front queue");

	// a division is bit-serial, so done never comes twice in a row
	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |=> !div_res.done)
		else $error("divider done repeated");

endmodule

### tb/radix_digit_converter_unit_test.sv
`timescale 1ns / 1ps

module radix_digit_converter_unit_test;
	import rdc_pkg::*;

	localparam int RANDOM_ITEMS = 346;
	localparam int SEGMENTS     = 8;
	localparam int TAIL_CYCLES  = 64;
	// worst case: 368 items of 31 digits each, plus long pop stalls
	localparam int CYCLE_LIMIT  = 2_000_000;

	// digit glyphs, most significant byte holds digit 0
	localparam logic [16*8-1:0] GLYPHS = "0123456789ABCDEF";

	// one pending beat together with the idle profile it is sent under
	typedef struct {
		in_item_t    beat;
		int unsigned send_idle_pct;
		int unsigned pop_stall_pct;
		bit          settle;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	stim_t       pending_beats[$];
	out_item_t   expected_chars[$];
	int unsigned pop_stall_pct = 0;
	bit          draining = 1'b0;
	int          errors = 0;
	int          conversions = 0;
	int          chars_checked = 0;
	int          bad_base_seen = 0;
	int          longest_number = 0;
	int          cycle_count = 0;

	radix_digit_converter_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #4 clk = ~clk;

	// expected characters of one conversion, most significant digit first
	function automatic void predict_chars(input in_item_t beat);
		logic [VALUE_BITS-1:0] rest;
		logic [VALUE_BITS-1:0] radix;
		logic [DIGIT_W-1:0]    digit;
		logic [DIGIT_W-1:0]    remainders[$];
		out_item_t             want;
		rest  = beat.value;
		radix = VALUE_BITS'(beat.base);
		if (beat.base < BASE_MIN || beat.base > BASE_MAX) begin
			// radix out of range: one lone flagged beat
			want.digit_char = '0;
			want.last       = 1'b1;
			want.bad_base   = 1'b1;
			expected_chars.push_back(want);
			return;
		end
		// least significant remainder comes out of the divider first
		do begin
			remainders.push_back(DIGIT_W'(rest % radix));
			rest = rest / radix;
		end while (rest != '0);
		if (remainders.size() > longest_number)
			longest_number = remainders.size();
		while (remainders.size() > 0) begin
			digit = remainders.pop_back();
			want.digit_char = CHAR_W'(GLYPHS[(15 - digit) * 8 +: 8]);
			want.last       = (remainders.size() == 0);
			want.bad_base   = 1'b0;
			expected_chars.push_back(want);
		end
	endfunction

	function automatic void queue_beat(input logic [VALUE_BITS-1:0] value,
		input logic [BASE_W-1:0] base, input int unsigned send_pct,
		input int unsigned stall_pct, input bit settle);
		stim_t s;
		s.beat.value    = value;
		s.beat.base     = base;
		s.send_idle_pct = send_pct;
		s.pop_stall_pct = stall_pct;
		s.settle        = settle;
		pending_beats.push_back(s);
	endfunction

	// values that stress the digit count: tiny, mid, powers of the radix and full width
	function automatic logic [VALUE_BITS-1:0] pick_value(input logic [BASE_W-1:0] base);
		longint unsigned v;
		longint unsigned b;
		b = (base < BASE_MIN) ? 2 : base;
		case ($urandom_range(9))
			0, 1, 2: v = $urandom_range(255);
			3:       v = $urandom_range(65535);
			4: begin
				// near a power of the radix, where the digit count steps
				v = 1;
				repeat ($urandom_range(1, 30))
					if (v * b < (64'd1 << VALUE_BITS)) v = v * b;
				v = v - $urandom_range(0, 1);
			end
			5:       v = (64'd1 << VALUE_BITS) - 1 - $urandom_range(3);
			default: v = $urandom;
		endcase
		return VALUE_BITS'(v);
	endfunction

	// driver: launch pending beats, hold each until the block takes it
	always @(posedge clk) begin : drive_blk
		logic  took;
		logic  next_push;
		stim_t head;
		took      = push && !full;
		next_push = 1'b0;
		if (took) begin
			predict_chars(item);
			conversions++;
		end
		if (!arst_n) begin
			next_push = 1'b0;
		end else if (push && !took) begin
			// beat not taken yet, keep it on the bus
			next_push = 1'b1;
		end else if (pending_beats.size() > 0) begin
			head = pending_beats[0];
			// settle: sender waits for every outstanding digit to drain
			if (!(head.settle && expected_chars.size() > 0) &&
					$urandom_range(99) >= head.send_idle_pct) begin
				next_push = 1'b1;
				item <= head.beat;
				pop_stall_pct <= head.pop_stall_pct;
				void'(pending_beats.pop_front());
			end
		end
		push <= next_push;
	end

	// monitor: pop digits at random and compare against the oldest expectation
	always @(posedge clk) begin : check_blk
		out_item_t   want;
		int unsigned stall;
		stall = draining ? 0 : pop_stall_pct;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				chars_checked++;
				if (result.bad_base) bad_base_seen++;
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected beat: char %h last %b bad_base %b", $time,
						result.digit_char, result.last, result.bad_base);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					if (result.digit_char !== want.digit_char) begin
						$display("%0t: digit_char expected %h got %h", $time,
							want.digit_char, result.digit_char);
						errors++;
					end
					if (result.last !== want.last) begin
						$display("%0t: last expected %b got %b", $time, want.last, result.last);
						errors++;
					end
					if (result.bad_base !== want.bad_base) begin
						$display("%0t: bad_base expected %b got %b", $time,
							want.bad_base, result.bad_base);
						errors++;
					end
				end
			end
			pop <= ($urandom_range(99) >= stall);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[radix_digit_converter_unit] ERROR");
			$finish;
		end
	end

	initial begin : stimulus_blk
		int unsigned          seg_len;
		int unsigned          phase;
		int unsigned          send_pct[4];
		int unsigned          stall_pct[4];
		logic [BASE_W-1:0]    base;
		send_pct  = '{0, 65, 0, 13};
		stall_pct = '{0, 0, 65, 13};

		// directed: zero, one, full width, digit glyph edges, every bad radix class
		queue_beat('0, 5'd2, 0, 0, 0);
		queue_beat('0, 5'd10, 0, 0, 0);
		queue_beat('0, 5'd16, 0, 0, 0);
		queue_beat(31'd1, 5'd2, 0, 0, 0);
		queue_beat('1, 5'd2, 0, 0, 0);
		queue_beat('1, 5'd3, 0, 0, 0);
		queue_beat('1, 5'd10, 0, 0, 0);
		queue_beat('1, 5'd16, 0, 0, 0);
		queue_beat(31'd15, 5'd16, 0, 0, 0);
		queue_beat(31'd255, 5'd16, 0, 0, 0);
		queue_beat(31'd10, 5'd11, 0, 0, 0);
		queue_beat(31'd10, 5'd10, 0, 0, 0);
		queue_beat(31'd9, 5'd10, 0, 0, 0);
		queue_beat(31'd1, 5'd16, 0, 0, 0);
		queue_beat(31'h5555_5555, 5'd2, 0, 0, 0);
		queue_beat(31'h2AAA_AAAA, 5'd4, 0, 0, 0);
		queue_beat(31'h1234_5678, 5'd7, 0, 0, 0);
		queue_beat(31'd12345, 5'd0, 0, 0, 0);
		queue_beat('1, 5'd1, 0, 0, 0);
		queue_beat('0, 5'd17, 0, 0, 0);
		queue_beat('1, 5'd31, 0, 0, 0);
		queue_beat(31'd99, 5'd24, 0, 0, 0);

		// random part in segments that walk through the idle profiles twice
		seg_len = RANDOM_ITEMS / SEGMENTS;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			phase = (i / seg_len) % 4;
			if ($urandom_range(99) < 12)
				base = BASE_W'($urandom_range(31));
			else
				base = BASE_W'($urandom_range(2, 16));
			queue_beat(pick_value(base), base, send_pct[phase], stall_pct[phase],
				(i % seg_len) == 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// every beat accepted, then every digit drained
		while (pending_beats.size() > 0 || push) @(posedge clk);
		while (expected_chars.size() > 0) @(posedge clk);
		draining = 1'b1;
		// watch for stray digits after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_chars.size() != 0) begin
			$display("%0t: %0d expected digits never arrived", $time, expected_chars.size());
			errors++;
		end
		$display("converted %0d numbers in bases 0-31 (%0d digits checked, %0d bad radix beats)",
			conversions, chars_checked, bad_base_seen);
		$display("longest number had %0d digits; idle and stall profiles all exercised",
			longest_number);
		if (errors == 0) begin
			$display("[radix_digit_converter_unit] OK");
		end else begin
			$display("[radix_digit_converter_unit] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
sv/rdc_pkg.sv
sv/rdc_front.sv
sv/rdc_div.sv
sv/rdc_back.sv
sv/radix_digit_converter_unit.sv
tb/radix_digit_converter_unit_test.sv
